### rtl/cbts_pkg.sv
// cbts_pkg: shared widths, status codes and the search result bundle
// for the can bit timing search block; no dependencies
`timescale 1ns / 1ps
`default_nettype none

package cbts_pkg;

  localparam int unsigned ClkW    = 28;  // main clock rate register
  localparam int unsigned RateW   = 20;  // requested bit rate
  localparam int unsigned StatusW = 2;
  localparam int unsigned DivW    = 4;   // prescale divider minus one
  localparam int unsigned TwW     = 15;  // packed timing word
  localparam int unsigned ProdW   = 14;  // segs * quanta * (div + 1) <= 8704
  localparam int unsigned MulW    = 10;  // quanta * (div + 1) <= 512
  localparam int unsigned DivCntW = 5;   // bit counter of the serial divider

  localparam logic [ClkW-1:0] ClkReset = ClkW'(48000000);

  localparam logic [DivW-1:0] DivLast    = 4'd15;
  localparam logic [5:0]      QuantaLast = 6'd32;
  localparam logic [4:0]      SegsFirst  = 5'd3;
  localparam logic [4:0]      SegsLast   = 5'd17;

  localparam logic [StatusW-1:0] StatusMatch   = 2'd0;
  localparam logic [StatusW-1:0] StatusNoMatch = 2'd1;
  localparam logic [StatusW-1:0] StatusZero    = 2'd2;

  typedef struct packed {
    logic            found;
    logic [DivW-1:0] div;
    logic [TwW-1:0]  tw;
  } srch_res_t;

endpackage

`default_nettype wire

### rtl/cbts_divider.sv
// cbts_divider: restoring bit-serial divider, one quotient bit per cycle
// depends on cbts_pkg
`timescale 1ns / 1ps
`default_nettype none

module cbts_divider import cbts_pkg::*; (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             start_i,
  input  wire logic [ClkW-1:0]  dividend_i,
  input  wire logic [RateW-1:0] divisor_i,
  output logic                  done_o,
  output logic [ClkW-1:0]       quot_o
);

  logic                busy_q, busy_d;
  logic [DivCntW-1:0]  cnt_q, cnt_d;
  logic [RateW-1:0]    rem_q, rem_d;
  logic [RateW-1:0]    dsr_q, dsr_d;
  logic [ClkW-1:0]     dq_q, dq_d;
  logic [RateW:0]      rem_sh;
  logic [RateW:0]      diff;
  logic                ge;

  // shift in the next dividend bit, subtract when it fits
  assign rem_sh = {rem_q, dq_q[ClkW-1]};
  assign ge     = rem_sh >= {1'b0, dsr_q};
  assign diff   = rem_sh - {1'b0, dsr_q};

  always_comb begin
    busy_d = busy_q;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    dsr_d  = dsr_q;
    dq_d   = dq_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = DivCntW'(ClkW - 1);
      rem_d  = '0;
      dsr_d  = divisor_i;
      dq_d   = dividend_i;
    end else if (busy_q) begin
      rem_d = ge ? diff[RateW-1:0] : rem_sh[RateW-1:0];
      dq_d  = {dq_q[ClkW-2:0], ge};
      cnt_d = cnt_q - DivCntW'(1);
      if (cnt_q == '0) begin
        busy_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    dsr_q <= dsr_d;
    dq_q  <= dq_d;
  end

  // quotient is complete once the last step is registered; done rises with it
  logic fin_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fin_q <= 1'b0;
    end else begin
      fin_q <= busy_q && (cnt_q == '0) && !start_i;
    end
  end

  assign done_o = fin_q;
  assign quot_o = dq_q;

endmodule

`default_nettype wire

### rtl/cbts_search.sv
// cbts_search: walks divider, quanta and segment total one candidate per cycle
// with incremental products; depends on cbts_pkg
`timescale 1ns / 1ps
`default_nettype none

module cbts_search import cbts_pkg::*; (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            start_i,
  input  wire logic [ClkW-1:0] cpb_i,
  output logic                 done_o,
  output srch_res_t            res_o
);

  logic            run_q, run_d;
  logic [DivW-1:0] dv_q, dv_d;
  logic [5:0]      qn_q, qn_d;
  logic [4:0]      sg_q, sg_d;
  logic [MulW-1:0] m_q, m_d;    // quanta * (div + 1)
  logic [ProdW-1:0] p_q, p_d;   // segs * m
  srch_res_t       res_q, res_d;

  logic            hit;
  logic            last;
  logic [MulW-1:0] m_nq;
  logic [MulW-1:0] m_ndv;
  logic [3:0]      rest;
  logic [3:0]      seg1;
  logic [2:0]      seg2;
  logic [1:0]      sjw;
  logic [5:0]      qm1;

  assign hit   = run_q && (cpb_i == {{(ClkW-ProdW){1'b0}}, p_q});
  assign last  = (sg_q == SegsLast) && (qn_q == QuantaLast) && (dv_q == DivLast);
  assign m_nq  = m_q + MulW'(dv_q) + MulW'(1);
  assign m_ndv = MulW'(dv_q) + MulW'(2);

  // segment split of the current candidate
  assign rest = 4'(sg_q - SegsFirst);
  assign seg1 = {1'b0, rest[3:1]};
  assign seg2 = 3'(rest - seg1);
  assign sjw  = (seg1 > 4'd3) ? 2'd3 : seg1[1:0];
  assign qm1  = qn_q - 6'd1;

  always_comb begin
    run_d = run_q;
    dv_d  = dv_q;
    qn_d  = qn_q;
    sg_d  = sg_q;
    m_d   = m_q;
    p_d   = p_q;
    res_d = res_q;
    if (start_i) begin
      run_d = 1'b1;
      dv_d  = '0;
      qn_d  = 6'd1;
      sg_d  = SegsFirst;
      m_d   = MulW'(1);
      p_d   = ProdW'(SegsFirst);
    end else if (run_q) begin
      if (hit) begin
        run_d       = 1'b0;
        res_d.found = 1'b1;
        res_d.div   = dv_q;
        res_d.tw    = {seg2, seg1, sjw, qm1};
      end else if (last) begin
        run_d       = 1'b0;
        res_d.found = 1'b0;
        res_d.div   = '0;
        res_d.tw    = '0;
      end else if (sg_q != SegsLast) begin
        sg_d = sg_q + 5'd1;
        p_d  = p_q + ProdW'(m_q);
      end else if (qn_q != QuantaLast) begin
        qn_d = qn_q + 6'd1;
        sg_d = SegsFirst;
        m_d  = m_nq;
        p_d  = ProdW'({m_nq, 1'b0}) + ProdW'(m_nq);
      end else begin
        dv_d = dv_q + DivW'(1);
        qn_d = 6'd1;
        sg_d = SegsFirst;
        m_d  = m_ndv;
        p_d  = ProdW'({m_ndv, 1'b0}) + ProdW'(m_ndv);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q <= 1'b0;
    end else begin
      run_q <= run_d;
    end
  end

  always_ff @(posedge clk_i) begin
    dv_q  <= dv_d;
    qn_q  <= qn_d;
    sg_q  <= sg_d;
    m_q   <= m_d;
    p_q   <= p_d;
    res_q <= res_d;
  end

  // result registers settle at the edge that ends the walk
  logic fin_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fin_q <= 1'b0;
    end else begin
      fin_q <= run_q && (hit || last) && !start_i;
    end
  end

  assign done_o = fin_q;
  assign res_o  = res_q;

endmodule

`default_nettype wire

### rtl/can_bit_timing_search.sv
// can_bit_timing_search: top level, clock-rate register, control sequencer
// and output register; depends on cbts_pkg, cbts_divider and cbts_search
`timescale 1ns / 1ps
`default_nettype none

//  channel | direction | handshake                | payload
//  --------+-----------+--------------------------+---------------------------------------
//  cfg     | in        | cfg_valid_i / cfg_ready_o | cfg_main_clock_hz_i
//  in      | in        | in_valid_i / in_stall_o   | bit_rate_i
//  out     | out       | out_valid_o / out_stall_i | status_o, prescale_div_o, timing_word_o
//
//  one request at a time: the bit-serial divider first computes clocks per bit,
//  then the search walk tests one candidate per cycle (up to 7680 candidates),
//  and the sequencer hands the result to the output register; the next request
//  can be taken in the same cycle as the result is first offered
//  a zero bit rate still runs the divide but skips the walk
//  reset clears the sequencer and sets the clock rate to 48 MHz
//  the finished result waits in the output register while out_stall_i is high;
//  in_stall_o stays high until the sequencer is back in idle

module can_bit_timing_search import cbts_pkg::*; (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  // configuration
  input  wire logic               cfg_valid_i,
  output logic                    cfg_ready_o,
  input  wire logic [ClkW-1:0]    cfg_main_clock_hz_i,
  // request
  input  wire logic               in_valid_i,
  output logic                    in_stall_o,
  input  wire logic [RateW-1:0]   bit_rate_i,
  // result
  output logic                    out_valid_o,
  input  wire logic               out_stall_i,
  output logic [StatusW-1:0]      status_o,
  output logic [DivW-1:0]         prescale_div_o,
  output logic [TwW-1:0]          timing_word_o
);

  typedef enum logic [3:0] {
    StIdle = 4'b0001,
    StDiv  = 4'b0010,
    StSrch = 4'b0100,
    StDone = 4'b1000
  } state_e;

  state_e state_q, state_d;

  logic [ClkW-1:0]    clk_hz_q;
  logic               zero_q, zero_d;
  logic               in_xfer;
  logic               out_free;
  logic               div_done;
  logic [ClkW-1:0]    quot;
  logic               srch_start;
  logic               srch_done;
  srch_res_t          srch_res;

  logic               out_valid_q, out_valid_d;
  logic [StatusW-1:0] status_q, status_d;
  logic [DivW-1:0]    div_q, div_d;
  logic [TwW-1:0]     tw_q, tw_d;

  // configuration is always taken
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clk_hz_q <= ClkReset;
    end else if (cfg_valid_i) begin
      clk_hz_q <= cfg_main_clock_hz_i;
    end
  end

  assign in_stall_o = (state_q != StIdle);
  assign in_xfer    = in_valid_i && !in_stall_o;
  assign out_free   = !out_valid_q || !out_stall_i;

  // clocks per bit, one quotient bit a cycle
  cbts_divider u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (in_xfer),
    .dividend_i (clk_hz_q),
    .divisor_i  (bit_rate_i),
    .done_o     (div_done),
    .quot_o     (quot)
  );

  assign srch_start = (state_q == StDiv) && div_done && !zero_q;

  // candidate walk over divider, quanta and segment total
  cbts_search u_srch (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (srch_start),
    .cpb_i   (quot),
    .done_o  (srch_done),
    .res_o   (srch_res)
  );

  // sequencer
  always_comb begin
    state_d = state_q;
    zero_d  = zero_q;
    case (state_q)
      StIdle: begin
        if (in_xfer) begin
          zero_d  = (bit_rate_i == '0);
          state_d = StDiv;
        end
      end
      StDiv: begin
        if (div_done) begin
          state_d = zero_q ? StDone : StSrch;
        end
      end
      StSrch: begin
        if (srch_done) begin
          state_d = StDone;
        end
      end
      StDone: begin
        if (out_free) begin
          state_d = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  // output register, loaded when the result is ready and the slot is free
  always_comb begin
    out_valid_d = out_valid_q;
    status_d    = status_q;
    div_d       = div_q;
    tw_d        = tw_q;
    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
    if ((state_q == StDone) && out_free) begin
      out_valid_d = 1'b1;
      if (zero_q) begin
        status_d = StatusZero;
        div_d    = '0;
        tw_d     = '0;
      end else if (srch_res.found) begin
        status_d = StatusMatch;
        div_d    = srch_res.div;
        tw_d     = srch_res.tw;
      end else begin
        status_d = StatusNoMatch;
        div_d    = '0;
        tw_d     = '0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      zero_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      zero_q      <= zero_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    status_q <= status_d;
    div_q    <= div_d;
    tw_q     <= tw_d;
  end

  assign out_valid_o    = out_valid_q;
  assign status_o       = status_q;
  assign prescale_div_o = div_q;
  assign timing_word_o  = tw_q;

endmodule

`default_nettype wire

### bench/can_bit_timing_search_test.sv
`timescale 1ns / 1ps
// can_bit_timing_search_test: self-checking bench for the can bit timing search block
// depends on cbts_pkg and can_bit_timing_search; directed table first, then random requests

module can_bit_timing_search_test;
  import cbts_pkg::*;

  localparam int unsigned RateMax    = (1 << RateW) - 1;
  localparam int unsigned CycleLimit = 4_000_000;  // watchdog bound on the whole run, with room for idling
  localparam int unsigned PrintCap   = 20;         // mismatch lines printed, all are counted
  localparam int unsigned NumPhases  = 3;
  localparam int unsigned NumBatches = 3;          // clock-rate settings per phase
  localparam int unsigned BatchLen   = 9;

  // one result transfer
  typedef struct packed {
    logic [StatusW-1:0] status;
    logic [DivW-1:0]    div;
    logic [TwW-1:0]     tw;
  } timing_t;

  // one directed request; typed rows carry their result, the rest use the predictor
  typedef struct packed {
    logic [ClkW-1:0]  hz;
    logic [RateW-1:0] rate;
    logic             typed;
    timing_t          want;
  } rate_row_t;

  localparam int unsigned NumRows = 23;
  localparam rate_row_t RateRows [NumRows] = '{
    // reset clock rate of 48 MHz
    '{28'd48000000,  20'd0,       1'b1, '{StatusZero,    4'd0, 15'd0}},
    '{28'd48000000,  20'd1000000, 1'b0, '0},
    '{28'd48000000,  20'hFFFFF,   1'b0, '0},
    '{28'd48000000,  20'd1,       1'b1, '{StatusNoMatch, 4'd0, 15'd0}},
    '{28'd48000000,  20'd500000,  1'b0, '0},
    '{28'd48000000,  20'd125000,  1'b0, '0},
    '{28'd48000000,  20'd50000,   1'b0, '0},
    '{28'd48000000,  20'd20000,   1'b0, '0},
    '{28'd48000000,  20'd33333,   1'b0, '0},
    '{28'd48000000,  20'd999999,  1'b0, '0},
    // clock rate of one: a quotient of one never matches
    '{28'd1,         20'd1,       1'b1, '{StatusNoMatch, 4'd0, 15'd0}},
    '{28'd1,         20'd0,       1'b1, '{StatusZero,    4'd0, 15'd0}},
    // a quotient of three: the smallest segment total, all fields zero
    '{28'd3,         20'd1,       1'b1, '{StatusMatch,   4'd0, 15'd0}},
    // zero clock rate gives a zero quotient
    '{28'd0,         20'd5,       1'b1, '{StatusNoMatch, 4'd0, 15'd0}},
    '{28'd0,         20'd0,       1'b1, '{StatusZero,    4'd0, 15'd0}},
    // largest product: divider 15, 32 quanta, 17 segments
    '{28'd8704,      20'd1,       1'b0, '0},
    '{28'd8705,      20'd1,       1'b0, '0},
    // clock rate of 200 MHz
    '{28'd200000000, 20'd1000000, 1'b0, '0},
    '{28'd200000000, 20'd12500,   1'b1, '{StatusNoMatch, 4'd0, 15'd0}},
    '{28'd200000000, 20'hFFFFF,   1'b0, '0},
    // all ones in the register
    '{28'hFFFFFFF,   20'hFFFFF,   1'b0, '0},
    '{28'hFFFFFFF,   20'd1,       1'b1, '{StatusNoMatch, 4'd0, 15'd0}},
    '{28'd48000000,  20'd250000,  1'b0, '0}
  };

  logic             clk_i        = 1'b0;
  logic             rst_n        = 1'b0;
  logic             cfg_valid    = 1'b0;
  logic [ClkW-1:0]  cfg_hz       = '0;
  logic             in_valid     = 1'b0;
  logic [RateW-1:0] bit_rate     = '0;
  logic             out_stall    = 1'b0;

  logic               cfg_ready;
  logic               in_stall;
  logic               out_valid;
  logic [StatusW-1:0] status;
  logic [DivW-1:0]    prescale_div;
  logic [TwW-1:0]     timing_word;

  // bench copy of the clock-rate register
  logic [ClkW-1:0] clk_rate_hz = ClkReset;

  timing_t     pending_timing[$];  // results owed by the block, oldest first
  timing_t     arrived_want;
  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;
  int unsigned cycles        = 0;
  int unsigned mismatches    = 0;
  int unsigned requests_sent = 0;
  int unsigned rate_writes   = 0;
  int unsigned seen_match    = 0;
  int unsigned seen_nomatch  = 0;
  int unsigned seen_zero     = 0;

  can_bit_timing_search uut (
    .clk_i               (clk_i),
    .rst_ni              (rst_n),
    .cfg_valid_i         (cfg_valid),
    .cfg_ready_o         (cfg_ready),
    .cfg_main_clock_hz_i (cfg_hz),
    .in_valid_i          (in_valid),
    .in_stall_o          (in_stall),
    .bit_rate_i          (bit_rate),
    .out_valid_o         (out_valid),
    .out_stall_i         (out_stall),
    .status_o            (status),
    .prescale_div_o      (prescale_div),
    .timing_word_o       (timing_word)
  );

  always #6 clk_i = ~clk_i;

  // expected timing for one bit rate: floor quotient of clocks per bit, then the
  // first divider / quanta / segment triple whose product hits it exactly
  function automatic timing_t search_timing(input logic [ClkW-1:0] hz,
                                            input logic [RateW-1:0] rate);
    timing_t     found;
    int unsigned per_bit;
    int unsigned rest;
    int unsigned seg1;
    int unsigned seg2;
    int unsigned sjw;
    found = '{StatusNoMatch, '0, '0};
    if (rate == '0) begin
      found.status = StatusZero;
      return found;
    end
    per_bit = int'(hz) / int'(rate);
    for (int unsigned d = 0; d <= int'(DivLast); d++) begin
      for (int unsigned q = 1; q <= int'(QuantaLast); q++) begin
        for (int unsigned s = int'(SegsFirst); s <= int'(SegsLast); s++) begin
          if (per_bit == s * q * (d + 1)) begin
            rest = s - int'(SegsFirst);
            seg1 = rest / 2;
            seg2 = rest - seg1;
            sjw  = (seg1 > 3) ? 3 : seg1;
            found.status = StatusMatch;
            found.div    = DivW'(d);
            found.tw     = {3'(seg2), 4'(seg1), 2'(sjw), 6'(q - 1)};
            return found;
          end
        end
      end
    end
    return found;
  endfunction

  // random bit rate: mostly rates built from a real triple so the search ends
  // early with a match, plus near misses, arbitrary rates and zero
  function automatic logic [RateW-1:0] pick_rate(input logic [ClkW-1:0] hz);
    int unsigned roll;
    int unsigned d;
    int unsigned q;
    int unsigned s;
    int unsigned r;
    roll = $urandom_range(99);
    if (roll < 5) return '0;
    if (roll < 20) return RateW'($urandom_range(RateMax, 1));
    for (int k = 0; k < 4; k++) begin
      // small dividers keep the walk short, now and then a deep one
      d = ($urandom_range(9) == 0) ? $urandom_range(15) : $urandom_range(3);
      q = $urandom_range(32, 1);
      s = $urandom_range(17, 3);
      r = int'(hz) / (s * q * (d + 1));
      if (roll < 30) r = r + 1;  // near miss, usually no exact quotient
      if (r >= 1 && r <= RateMax) return RateW'(r);
    end
    return RateW'($urandom_range(RateMax, 1));
  endfunction

  task automatic report_mismatch(input string msg);
    mismatches++;
    if (mismatches <= PrintCap) $display("mismatch at cycle %0d: %s", cycles, msg);
  endtask

  // one request transfer, entered and left at a falling edge; valid stays high
  // on return so back-to-back requests need no extra step
  task automatic send_rate(input logic [RateW-1:0] rate, input timing_t want);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk_i);
    end
    in_valid <= 1'b1;
    bit_rate <= rate;
    @(posedge clk_i);
    while (in_stall) @(posedge clk_i);
    pending_timing.push_back(want);
    requests_sent++;
    @(negedge clk_i);
  endtask

  // sender holds off until every owed result has come back
  task automatic wait_drained();
    in_valid <= 1'b0;
    while (pending_timing.size() != 0) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  // register write, only issued with the block idle
  task automatic write_clock_rate(input logic [ClkW-1:0] hz);
    cfg_valid <= 1'b1;
    cfg_hz    <= hz;
    @(posedge clk_i);
    while (!cfg_ready) @(posedge clk_i);
    clk_rate_hz = hz;
    rate_writes++;
    @(negedge clk_i);
    cfg_valid <= 1'b0;
  endtask

  // receiver stall pattern, changed at falling edges only
  always @(negedge clk_i) begin
    out_stall <= (recv_idle_pct != 0) && ($urandom_range(99) < recv_idle_pct);
  end

  // result checker: compares each accepted transfer with the oldest expectation
  always @(posedge clk_i) begin
    if (rst_n && out_valid && !out_stall) begin
      if (pending_timing.size() == 0) begin
        report_mismatch($sformatf("result with nothing pending (status %0d)", status));
      end else begin
        arrived_want = pending_timing.pop_front();
        if (status != arrived_want.status)
          report_mismatch($sformatf("status %0d, want %0d", status, arrived_want.status));
        if (prescale_div != arrived_want.div)
          report_mismatch($sformatf("prescale_div %0d, want %0d",
                                    prescale_div, arrived_want.div));
        if (timing_word != arrived_want.tw)
          report_mismatch($sformatf("timing_word 0x%04h, want 0x%04h",
                                    timing_word, arrived_want.tw));
        case (status)
          StatusMatch:   seen_match++;
          StatusNoMatch: seen_nomatch++;
          default:       seen_zero++;
        endcase
      end
    end
  end

  // watchdog
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles >= CycleLimit) begin
      $display("run stopped at cycle limit with %0d results outstanding",
               pending_timing.size());
      $display("FAILURE");
      $finish;
    end
  end

  initial begin
    logic [ClkW-1:0]  next_hz;
    logic [RateW-1:0] rate;
    timing_t          want;

    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_n <= 1'b1;
    @(negedge clk_i);

    // directed table, no idling; a new clock rate drains the block first
    foreach (RateRows[i]) begin
      if (RateRows[i].hz != clk_rate_hz) begin
        wait_drained();
        write_clock_rate(RateRows[i].hz);
      end
      want = RateRows[i].typed ? RateRows[i].want
                               : search_timing(clk_rate_hz, RateRows[i].rate);
      send_rate(RateRows[i].rate, want);
    end

    // random part: receiver-heavy idling, then sender-heavy, then none
    for (int p = 0; p < NumPhases; p++) begin
      send_idle_pct = (p == 0) ? 35 : (p == 1) ? 60 : 0;
      recv_idle_pct = (p == 0) ? 60 : (p == 1) ? 35 : 0;
      for (int b = 0; b < NumBatches; b++) begin
        // fresh clock rate per batch, the top of the range now and then
        next_hz = ($urandom_range(4) == 0) ? ClkW'(200000000)
                                           : ClkW'($urandom_range(200000000, 8000000));
        wait_drained();
        write_clock_rate(next_hz);
        for (int n = 0; n < BatchLen; n++) begin
          rate = pick_rate(clk_rate_hz);
          send_rate(rate, search_timing(clk_rate_hz, rate));
        end
      end
    end

    wait_drained();
    recv_idle_pct = 0;
    repeat (60) @(posedge clk_i);

    $display("checked %0d bit-rate requests under %0d clock-rate writes, with and without idling",
             requests_sent, rate_writes);
    $display("results: %0d exact, %0d without exact match, %0d zero rate, %0d mismatches",
             seen_match, seen_nomatch, seen_zero, mismatches);
    if (mismatches == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
